// ===== sv/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// shared codes and result type for the positional list store
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int OpcodeW = 2;
  localparam int PosW    = 6;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 7;

  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  localparam logic [OpcodeW-1:0] OP_APPEND = 2'd0;
  localparam logic [OpcodeW-1:0] OP_READ   = 2'd1;
  localparam logic [OpcodeW-1:0] OP_DELETE = 2'd2;

  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [ValueW-1:0]  read_value;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/pls_ram.sv =====
// ----------------------------------------------------------------------------
// pls_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl
// sequencer: decodes one operation, drives the store, walks the delete shift
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pls_pkg::OpcodeW-1:0]   opcode,
  input  wire logic [pls_pkg::PosW-1:0]      position,
  input  wire logic [pls_pkg::ValueW-1:0]    value,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output pls_pkg::result_t                   res,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [31:0]                        ram_wdata,
  output logic [AW-1:0]                      ram_raddr,
  input  wire logic [31:0]                   ram_rdata
);

  localparam int PW = (CW > pls_pkg::PosW) ? CW : pls_pkg::PosW;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] wq, wq_next;
  logic pend, pend_next;
  logic [pls_pkg::ValueW-1:0]  res_value, res_value_next;
  logic [pls_pkg::StatusW-1:0] res_status, res_status_next;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [AW:0]   ptr_inc;
  logic          in_range;
  logic          more;

  assign pos_w    = PW'(position);
  assign cnt_w    = PW'(count);
  assign in_range = pos_w < cnt_w;
  assign ptr_inc  = {1'b0, ptr} + (AW+1)'(1);
  assign more     = ptr_inc < (AW+1)'(count);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.read_value = res_value;
  assign res.status     = res_status;
  assign res.count      = pls_pkg::CountW'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    wq_next         = wq;
    pend_next       = pend;
    res_value_next  = res_value;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = count[AW-1:0];
    ram_wdata       = value;
    ram_raddr       = pos_w[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_value_next  = '0;
          res_status_next = pls_pkg::ST_DONE;
          state_next      = S_DONE;
          unique case (opcode)
            pls_pkg::OP_APPEND: begin
              if (count >= CW'(DEPTH)) begin
                res_status_next = pls_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            pls_pkg::OP_READ: begin
              if (!in_range) begin
                res_status_next = pls_pkg::ST_RANGE;
              end else begin
                state_next = S_RDWAIT;
              end
            end
            pls_pkg::OP_DELETE: begin
              if (!in_range) begin
                res_status_next = pls_pkg::ST_RANGE;
              end else begin
                ptr_next   = pos_w[AW-1:0];
                pend_next  = 1'b0;
                state_next = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_value_next = ram_rdata;
        state_next     = S_DONE;
      end
      S_SHIFT: begin
        ram_raddr = ptr_inc[AW-1:0];
        ram_waddr = wq;
        ram_wdata = ram_rdata;
        ram_we    = pend;
        if (more) begin
          wq_next   = ptr;
          ptr_next  = ptr_inc[AW-1:0];
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    wq         <= wq_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

endmodule

`default_nettype wire

// ===== sv/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed 32-bit values with append, read and delete
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per transfer; m_axis returns one result
//   per operation with read value, status and the count afterwards.
//   sequencer steps from input transfer to result valid:
//     append, refused operation, unused opcode: straight to the result
//     read: a wait state for the registered store read
//     delete at position p with count n: entries p + 1 to n - 1 shift down, one entry
//     moved per cycle through the store write port and registered read port
//   s_axis_tready is high only while the sequencer is idle, so a delete
//   holds the input while it shifts the entries.
//   the result sits in an output register; the next operation is taken
//   while it waits, and a finished result waits in the sequencer until
//   the output register frees.
//   reset clears the count and the handshake state; the store contents
//   are not cleared and only entries below the count are used.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[1:0], position[7:2], value[39:8]
  input  wire logic [pls_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // read_value[31:0], status[33:32], count[40:34], zero fill[47:41]
  output logic      [pls_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;
  logic             res_valid;
  logic             res_ready;
  pls_pkg::result_t res;
  pls_pkg::result_t out_q;
  logic             out_valid;

  assign res_ready = !out_valid || m_axis_tready;

  pls_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .opcode    (s_axis_tdata[1:0]),
    .position  (s_axis_tdata[7:2]),
    .value     (s_axis_tdata[39:8]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pls_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_q.count, out_q.status, out_q.read_value};

endmodule

`default_nettype wire

// ===== dv/positional_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_tb
// drives append, read and delete transfers into the list store and checks
// every result against a fixed typed result or a local list model, with random
// stalls on both sides
`timescale 1ns / 100ps

module positional_list_store_tb;

  localparam int Depth       = 64;
  localparam int NumDirected = 24;
  localparam int NumRandom   = 900;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = Depth + 16;
  localparam int LongHold    = 400;

  localparam logic [pls_pkg::OpcodeW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [pls_pkg::OpcodeW-1:0] opcode;
    logic [pls_pkg::PosW-1:0]    position;
    logic [pls_pkg::ValueW-1:0]  value;
    logic                        fixed;
    pls_pkg::result_t            result;
  } dir_row_t;

  // fixed rows carry a typed result, the others go through the list model
  localparam dir_row_t DirRows [NumDirected] = '{
    '{pls_pkg::OP_READ, 6'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_RANGE, 7'd0}},
    '{pls_pkg::OP_DELETE, 6'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_RANGE, 7'd0}},
    '{pls_pkg::OP_READ, 6'd63, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_RANGE, 7'd0}},
    '{OP_UNUSED, 6'd63, 32'hffff_ffff, 1'b1, '{32'h0000_0000, pls_pkg::ST_DONE, 7'd0}},
    '{pls_pkg::OP_APPEND, 6'd0, 32'h8000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_DONE, 7'd1}},
    '{pls_pkg::OP_APPEND, 6'd63, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, pls_pkg::ST_DONE, 7'd2}},
    '{pls_pkg::OP_APPEND, 6'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_DONE, 7'd3}},
    '{pls_pkg::OP_APPEND, 6'd0, 32'hffff_ffff, 1'b1, '{32'h0000_0000, pls_pkg::ST_DONE, 7'd4}},
    '{pls_pkg::OP_READ, 6'd0, 32'h0000_0000, 1'b1, '{32'h8000_0000, pls_pkg::ST_DONE, 7'd4}},
    '{pls_pkg::OP_READ, 6'd1, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, pls_pkg::ST_DONE, 7'd4}},
    '{pls_pkg::OP_READ, 6'd3, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, pls_pkg::ST_DONE, 7'd4}},
    '{pls_pkg::OP_READ, 6'd4, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_RANGE, 7'd4}},
    '{pls_pkg::OP_DELETE, 6'd63, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_RANGE, 7'd4}},
    '{pls_pkg::OP_DELETE, 6'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, pls_pkg::ST_DONE, 7'd3}},
    '{pls_pkg::OP_READ,   6'd0,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_READ,   6'd2,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_DELETE, 6'd2,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_APPEND, 6'd0,  32'h5a5a_5a5a, 1'b0, '0},
    '{pls_pkg::OP_DELETE, 6'd1,  32'h0000_0000, 1'b0, '0},
    '{OP_UNUSED,          6'd0,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_READ,   6'd1,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_DELETE, 6'd0,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_DELETE, 6'd0,  32'h0000_0000, 1'b0, '0},
    '{pls_pkg::OP_READ,   6'd0,  32'h0000_0000, 1'b0, '0}
  };

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [pls_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [pls_pkg::OutDataW-1:0] m_axis_tdata;

  logic [pls_pkg::ValueW-1:0] list_mem [Depth];
  int unsigned                list_len;
  pls_pkg::result_t           expected_results [$];
  int                         mismatches;
  int                         results_seen;
  int                         idle_cycles;
  int                         ready_stall;
  bit                         long_hold_done;

  positional_list_store #(
    .DEPTH(Depth)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  function automatic pls_pkg::result_t apply_list_op(
      input logic [pls_pkg::OpcodeW-1:0] op,
      input logic [pls_pkg::PosW-1:0] pos,
      input logic [pls_pkg::ValueW-1:0] val);
    pls_pkg::result_t res;
    int unsigned      i;
    res.read_value = '0;
    res.status     = pls_pkg::ST_DONE;
    case (op)
      pls_pkg::OP_APPEND: begin
        if (list_len >= Depth) begin
          res.status = pls_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      pls_pkg::OP_READ: begin
        if (pos >= list_len) res.status = pls_pkg::ST_RANGE;
        else res.read_value = list_mem[pos];
      end
      pls_pkg::OP_DELETE: begin
        if (pos >= list_len) begin
          res.status = pls_pkg::ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    res.count = list_len[pls_pkg::CountW-1:0];
    return res;
  endfunction

  // growing phases lean on appends to reach a full list, shrinking on deletes
  function automatic logic [pls_pkg::OpcodeW-1:0] pick_op(input bit growing);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 75) return pls_pkg::OP_APPEND;
      if (roll < 93) return pls_pkg::OP_READ;
      if (roll < 97) return pls_pkg::OP_DELETE;
      return OP_UNUSED;
    end
    if (roll < 10) return pls_pkg::OP_APPEND;
    if (roll < 32) return pls_pkg::OP_READ;
    if (roll < 95) return pls_pkg::OP_DELETE;
    return OP_UNUSED;
  endfunction

  function automatic logic [pls_pkg::PosW-1:0] pick_pos();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80 && list_len > 0) begin
      return pls_pkg::PosW'($urandom_range(0, list_len - 1));
    end
    if (roll < 88) return pls_pkg::PosW'(list_len);
    return pls_pkg::PosW'($urandom_range(0, Depth - 1));
  endfunction

  function automatic logic [pls_pkg::ValueW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (roll < 20) return pls_pkg::ValueW'($urandom_range(0, 15)) - 32'd8;
    return $urandom;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, and back-to-back windows
  function automatic int pick_gap(input int idx);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (idx % 150 < 30) return 0;
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_op(input logic [pls_pkg::OpcodeW-1:0] op,
                         input logic [pls_pkg::PosW-1:0] pos,
                         input logic [pls_pkg::ValueW-1:0] val, input bit fixed,
                         input pls_pkg::result_t fixed_res, input int gap);
    pls_pkg::result_t predicted;
    s_axis_tdata  <= {val, pos, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_list_op(op, pos, val);
    expected_results.push_back(fixed ? fixed_res : predicted);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_result(input pls_pkg::result_t got);
    pls_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result value=%h status=%0d count=%0d", $time,
               got.read_value, got.status, got.count);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                 got.read_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_result('{m_axis_tdata[31:0], m_axis_tdata[33:32], m_axis_tdata[40:34]});
      results_seen++;
    end
  end

  // result side stalls, including one long hold that backs up the input
  always @(negedge clk) begin
    if (!long_hold_done && results_seen >= 400) begin
      ready_stall    = LongHold;
      long_hold_done = 1'b1;
    end else if (ready_stall == 0 && (results_seen / 100) % 3 != 0 &&
                 $urandom_range(0, 99) < 20) begin
      ready_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 60);
    end
    if (ready_stall > 0) begin
      m_axis_tready <= 1'b0;
      ready_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    list_len       = 0;
    mismatches     = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    ready_stall    = 0;
    long_hold_done = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumDirected; r++) begin
      send_op(DirRows[r].opcode, DirRows[r].position, DirRows[r].value,
              DirRows[r].fixed, DirRows[r].result, pick_gap(r));
    end
    drain_results();

    for (int k = 0; k < NumRandom; k++) begin
      if (k == NumRandom / 2) drain_results();
      send_op(pick_op(((k / 120) % 2) == 0), pick_pos(), pick_value(), 1'b0, '0,
              pick_gap(k));
    end
    drain_results();
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== positional_list_store.f =====
sv/pls_pkg.sv
sv/pls_ram.sv
sv/pls_ctrl.sv
sv/positional_list_store.sv
dv/positional_list_store_tb.sv
